>>> hw/rtl/atot_pkg.sv
// Shared constants and command codes for the abundance threshold occupancy table.
package atot_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int NUM_LEVELS  = 101;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int COL_W       = $clog2(MAX_SAMPLES);
  localparam int CELL_W      = 16;
  localparam int ROW_W       = MAX_SAMPLES * CELL_W;
  localparam int PCT_SCALE   = 100;

  localparam logic [LVL_W-1:0]  LVL_MAX   = LVL_W'(NUM_LEVELS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SAMPLES);
  localparam logic [CELL_W-1:0] CELL_SAT  = '1;
  localparam logic [15:0]       UNIT_CAP  = 16'hFFFF;
  localparam logic [16:0]       FRAC_ONE  = 17'h10000;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;
  localparam logic [1:0] REG_ABUND_LEVEL = 2'd1;
  localparam logic [1:0] REG_MIN_SAMPLES = 2'd2;
  localparam logic [1:0] REG_OUT_FRAC    = 2'd3;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_CELL    = 1'b1;

endpackage

>>> hw/rtl/atot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module atot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/abundance_threshold_occupancy_table_core.sv
// Top level: abundance threshold occupancy table with row-wide RAM sweeps.
//
// Commands enter on start/busy: an item is taken at a clock edge with start
// high and busy low. cmd 0 gives one sample's abundance of the current unit,
// cmd 1 reads one table cell, cmd 2 clears table, level counts and unit count.
// Results leave on result_valid for exactly one cycle; the receiver cannot
// stall, so every result is taken in the cycle it shows.
// Configuration writes use cfg_valid/cfg_ready (always ready), cfg_addr picks
// the register; write only while busy is low.
// Each item sweeps rows with one row read-modify-write per cycle on the level
// count RAM (and on the occupancy row RAM for a unit's last sample):
//   sample, not last   : sweep over levels 0..level
//   sample, last       : sweep over all 101 rows, summary after the last row
//   read, raw          : one row read;  read as fraction: radix-2 divider
//   clear              : all 101 rows cleared
// After reset a clearing pass runs with busy high.
module abundance_threshold_occupancy_table_core
  import atot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [16:0]        rel_abund,
  input  logic               last_sample,
  input  logic [6:0]         read_level,
  input  logic [6:0]         read_rank,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_addr,
  input  logic [7:0]         cfg_data,
  output logic               result_valid,
  output logic               kind,
  output logic [15:0]        unit_index,
  output logic [6:0]         count_at_abund,
  output logic signed [7:0]  top_level,
  output logic [16:0]        cell_value
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_RDAT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0] state;

  // configuration
  logic [6:0]        num_samples;
  logic signed [7:0] abund_level;
  logic signed [7:0] min_samples;
  logic              output_fraction;

  logic [CNT_W-1:0] ns_eff;
  logic [CNT_W-1:0] need;
  logic             top_en;
  logic             abund_ok;

  // sweep control
  logic [LVL_W-1:0] rd_idx;
  logic [LVL_W-1:0] rd_end;
  logic             rd_active;
  logic             proc_valid;
  logic [LVL_W-1:0] proc_idx;
  logic             close;
  logic [LVL_W-1:0] lvl;
  logic [CNT_W-1:0] cnt;
  logic signed [7:0] top;
  logic [15:0]      units_seen;
  logic             capped;

  // read path
  logic [COL_W-1:0] rd_col;
  logic             rd_ok;
  logic [31:0]      dq;
  logic [15:0]      rem;
  logic [4:0]       div_cnt;

  // memories
  logic             lc_we;
  logic [LVL_W-1:0] lc_waddr;
  logic [CNT_W-1:0] lc_wdata;
  logic [LVL_W-1:0] raddr;
  logic [CNT_W-1:0] lc_rdata;
  logic             tb_we;
  logic [LVL_W-1:0] tb_waddr;
  logic [ROW_W-1:0] tb_wdata;
  logic [ROW_W-1:0] tb_rdata;
  logic [ROW_W-1:0] row_inc;

  logic             accept;
  logic [23:0]      lvl_prod;
  logic [7:0]       lvl_raw;
  logic [LVL_W-1:0] lvl_in;
  logic [CNT_W-1:0] newc;
  logic [CNT_W-1:0] lim;
  logic [16:0]      trial;
  logic [15:0]      cell_sel;

  atot_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LEVELS)) u_lc_ram (
    .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
    .raddr(raddr), .rdata(lc_rdata)
  );

  atot_ram #(.WIDTH(ROW_W), .DEPTH(NUM_LEVELS)) u_tb_ram (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(raddr), .rdata(tb_rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign capped    = (units_seen == UNIT_CAP);

  always_comb begin
    if (num_samples == 7'd0) begin
      ns_eff = CNT_W'(1);
    end else if (num_samples > 7'(MAX_SAMPLES)) begin
      ns_eff = CNT_MAX;
    end else begin
      ns_eff = CNT_W'(num_samples);
    end
    if (min_samples >= 8'sd1 && min_samples <= $signed({1'b0, ns_eff})) begin
      need = CNT_W'(min_samples);
    end else begin
      need = ns_eff;
    end
    top_en   = (min_samples != -8'sd1);
    abund_ok = (abund_level >= 8'sd0) && (abund_level <= $signed({1'b0, LVL_MAX}));
  end

  // percent level of the incoming abundance, saturated at the top level
  always_comb begin
    lvl_prod = {7'd0, rel_abund} * 24'(PCT_SCALE);
    lvl_raw  = lvl_prod[23:16];
    lvl_in   = (lvl_raw > 8'(LVL_MAX)) ? LVL_MAX : lvl_raw[LVL_W-1:0];
  end

  // row update for the level under process
  always_comb begin
    if (proc_idx <= lvl && lc_rdata < CNT_MAX) begin
      newc = lc_rdata + CNT_W'(1);
    end else begin
      newc = lc_rdata;
    end
    lim = (newc < ns_eff) ? newc : ns_eff;
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      if (CNT_W'(k) < lim && tb_rdata[k*CELL_W +: CELL_W] != CELL_SAT) begin
        row_inc[k*CELL_W +: CELL_W] = tb_rdata[k*CELL_W +: CELL_W] + CELL_W'(1);
      end else begin
        row_inc[k*CELL_W +: CELL_W] = tb_rdata[k*CELL_W +: CELL_W];
      end
    end
  end

  always_comb begin
    cell_sel = tb_rdata[rd_col*CELL_W +: CELL_W];
    trial    = {rem, dq[31]};
  end

  // memory port steering
  always_comb begin
    lc_we    = 1'b0;
    lc_waddr = proc_idx;
    lc_wdata = close ? '0 : newc;
    tb_we    = 1'b0;
    tb_waddr = proc_idx;
    tb_wdata = row_inc;
    raddr    = rd_idx;
    case (state)
      S_CLR: begin
        lc_we    = 1'b1;
        lc_waddr = rd_idx;
        lc_wdata = '0;
        tb_we    = 1'b1;
        tb_waddr = rd_idx;
        tb_wdata = '0;
      end
      S_SWEEP: begin
        lc_we = proc_valid;
        tb_we = proc_valid && close && !capped;
      end
      S_IDLE: begin
        raddr = (read_level > 7'(LVL_MAX)) ? '0 : read_level[LVL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples     <= 7'd64;
      abund_level     <= -8'sd1;
      min_samples     <= -8'sd1;
      output_fraction <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_NUM_SAMPLES: num_samples     <= cfg_data[6:0];
        REG_ABUND_LEVEL: abund_level     <= cfg_data;
        REG_MIN_SAMPLES: min_samples     <= cfg_data;
        REG_OUT_FRAC:    output_fraction <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      rd_idx       <= '0;
      rd_active    <= 1'b0;
      proc_valid   <= 1'b0;
      result_valid <= 1'b0;
      units_seen   <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_SAMPLE: begin
                state     <= S_SWEEP;
                lvl       <= lvl_in;
                close     <= last_sample;
                rd_end    <= last_sample ? LVL_MAX : lvl_in;
                rd_idx    <= '0;
                rd_active <= 1'b1;
                cnt       <= '0;
                top       <= -8'sd1;
              end
              CMD_READ: begin
                state  <= S_RDAT;
                rd_col <= read_rank[COL_W-1:0] - COL_W'(1);
                rd_ok  <= (read_level <= 7'(LVL_MAX)) && (read_rank != 7'd0)
                          && (read_rank <= 7'(ns_eff));
              end
              CMD_CLEAR: begin
                state  <= S_CLR;
                rd_idx <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          rd_idx <= rd_idx + LVL_W'(1);
          if (rd_idx == LVL_MAX) begin
            state      <= S_IDLE;
            units_seen <= '0;
          end
        end
        S_SWEEP: begin
          // issue the next row read while the previous row writes back
          proc_valid <= rd_active;
          proc_idx   <= rd_idx;
          if (rd_active) begin
            if (rd_idx == rd_end) begin
              rd_active <= 1'b0;
            end else begin
              rd_idx <= rd_idx + LVL_W'(1);
            end
          end
          if (proc_valid) begin
            if (abund_ok && proc_idx == abund_level[LVL_W-1:0]) begin
              cnt <= newc;
            end
            if (top_en && newc >= need) begin
              top <= $signed({1'b0, proc_idx});
            end
            if (proc_idx == rd_end) begin
              proc_valid <= 1'b0;
              state      <= S_IDLE;
              if (close) begin
                result_valid   <= 1'b1;
                kind           <= KIND_SUMMARY;
                unit_index     <= capped ? UNIT_CAP - 16'd1 : units_seen;
                count_at_abund <= (abund_ok && proc_idx == abund_level[LVL_W-1:0])
                                  ? 7'(newc) : 7'(cnt);
                top_level <= (top_en && newc >= need) ? $signed({1'b0, proc_idx}) : top;
                cell_value <= '0;
                if (!capped) begin
                  units_seen <= units_seen + 16'd1;
                end
              end
            end
          end
        end
        S_RDAT: begin
          if (rd_ok && output_fraction && units_seen != 16'd0) begin
            state   <= S_DIV;
            dq      <= {cell_sel, 16'd0};
            rem     <= '0;
            div_cnt <= '0;
          end else begin
            state          <= S_IDLE;
            result_valid   <= 1'b1;
            kind           <= KIND_CELL;
            unit_index     <= '0;
            count_at_abund <= '0;
            top_level      <= -8'sd1;
            cell_value     <= (rd_ok && !output_fraction) ? {1'b0, cell_sel} : '0;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          div_cnt <= div_cnt + 5'd1;
          if (trial >= {1'b0, units_seen}) begin
            rem <= 16'(trial - {1'b0, units_seen});
            dq  <= {dq[30:0], 1'b1};
          end else begin
            rem <= trial[15:0];
            dq  <= {dq[30:0], 1'b0};
          end
          if (div_cnt == 5'd31) begin
            state          <= S_IDLE;
            result_valid   <= 1'b1;
            kind           <= KIND_CELL;
            unit_index     <= '0;
            count_at_abund <= '0;
            top_level      <= -8'sd1;
            if (dq[30:16] != 15'd0) begin
              cell_value <= FRAC_ONE;
            end else if (trial >= {1'b0, units_seen}) begin
              cell_value <= ({dq[15:0], 1'b1} > FRAC_ONE) ? FRAC_ONE : {dq[15:0], 1'b1};
            end else begin
              cell_value <= ({dq[15:0], 1'b0} > FRAC_ONE) ? FRAC_ONE : {dq[15:0], 1'b0};
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_SAMPLE || cmd == CMD_READ || cmd == CMD_CLEAR) |=> busy)
    else $error("accepted command did not raise busy");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_CELL |-> top_level == -8'sd1 && unit_index == 16'd0)
    else $error("cell result carries summary fields");

  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> units_seen != 16'd0)
    else $error("divider running with no units");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the abundance threshold occupancy table core.
module testbench;
  import atot_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic               kind;
    logic [15:0]        unit_index;
    logic [6:0]         count_at_abund;
    logic signed [7:0]  top_level;
    logic [16:0]        cell_value;
  } table_result_t;

  class occupancy_scoreboard;
    bit [6:0]          num_samples;
    logic signed [7:0] abund_level;
    logic signed [7:0] min_samples;
    bit                out_frac;
    bit [6:0]          level_cnt[NUM_LEVELS];
    bit [15:0]         occ[NUM_LEVELS][MAX_SAMPLES];
    int unsigned       units;
    table_result_t     pending[$];
    int                errors;

    function new();
      num_samples = 7'd64;
      abund_level = -8'sd1;
      min_samples = -8'sd1;
      out_frac    = 1'b1;
      errors      = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (level_cnt[j]) level_cnt[j] = '0;
      foreach (occ[j, k]) occ[j][k] = '0;
      units = 0;
    endfunction

    function int eff_samples();
      if (num_samples == 0) return 1;
      if (num_samples > MAX_SAMPLES) return MAX_SAMPLES;
      return num_samples;
    endfunction

    function void write_reg(logic [1:0] addr, logic [7:0] data);
      case (addr)
        REG_NUM_SAMPLES: num_samples = data[6:0];
        REG_ABUND_LEVEL: abund_level = data;
        REG_MIN_SAMPLES: min_samples = data;
        REG_OUT_FRAC:    out_frac    = data[0];
        default: ;
      endcase
    endfunction

    // Predict the effect of one accepted command.
    function void note_input(logic [1:0] c, logic [16:0] rel, logic lst,
                             logic [6:0] rlvl, logic [6:0] rrank);
      int ns, lvl, al, ms, need, top, cnt, idx, lim;
      longint unsigned val;
      table_result_t r;
      ns = eff_samples();
      if (c == CMD_SAMPLE) begin
        lvl = (longint'(rel) * 100) >> 16;
        if (lvl > NUM_LEVELS - 1) lvl = NUM_LEVELS - 1;
        for (int j = 0; j <= lvl; j++)
          if (level_cnt[j] < MAX_SAMPLES) level_cnt[j]++;
        if (!lst) return;
        al = abund_level;
        ms = min_samples;
        cnt = (al >= 0 && al < NUM_LEVELS) ? level_cnt[al] : 0;
        top = -1;
        if (ms != -1) begin
          need = (ms >= 1 && ms <= ns) ? ms : ns;
          for (int j = 0; j < NUM_LEVELS; j++)
            if (level_cnt[j] >= need) top = j;
        end
        if (units < 65535) begin
          idx = units;
          for (int j = 0; j < NUM_LEVELS; j++) begin
            lim = (level_cnt[j] < ns) ? level_cnt[j] : ns;
            for (int k = 0; k < lim; k++)
              if (occ[j][k] != 16'hFFFF) occ[j][k]++;
          end
          units++;
        end else begin
          idx = 65534;
        end
        foreach (level_cnt[j]) level_cnt[j] = '0;
        r.kind = KIND_SUMMARY;
        r.unit_index = idx[15:0];
        r.count_at_abund = cnt[6:0];
        r.top_level = top[7:0];
        r.cell_value = '0;
        pending = {pending, r};
      end else if (c == CMD_READ) begin
        val = 0;
        if (rlvl < NUM_LEVELS && rrank >= 1 && rrank <= ns) begin
          val = occ[rlvl][rrank - 1];
          if (out_frac) begin
            if (units == 0) val = 0;
            else begin
              val = (val << 16) / units;
              if (val > 65536) val = 65536;
            end
          end
        end
        r.kind = KIND_CELL;
        r.unit_index = '0;
        r.count_at_abund = '0;
        r.top_level = -8'sd1;
        r.cell_value = val[16:0];
        pending = {pending, r};
      end else if (c == CMD_CLEAR) begin
        clear_state();
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result exp none got kind=%0d cell=%0d", $time, got.kind,
                 got.cell_value);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
        errors++;
      end
      if (got.unit_index !== exp_r.unit_index) begin
        $display("%0t: unit_index exp %0d got %0d", $time, exp_r.unit_index, got.unit_index);
        errors++;
      end
      if (got.count_at_abund !== exp_r.count_at_abund) begin
        $display("%0t: count_at_abund exp %0d got %0d", $time, exp_r.count_at_abund,
                 got.count_at_abund);
        errors++;
      end
      if (got.top_level !== exp_r.top_level) begin
        $display("%0t: top_level exp %0d got %0d", $time, exp_r.top_level, got.top_level);
        errors++;
      end
      if (got.cell_value !== exp_r.cell_value) begin
        $display("%0t: cell_value exp %0d got %0d", $time, exp_r.cell_value, got.cell_value);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_SAMPLE;
  logic [16:0]        rel_abund = '0;
  logic               last_sample = 1'b0;
  logic [6:0]         read_level = '0;
  logic [6:0]         read_rank = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_addr = REG_NUM_SAMPLES;
  logic [7:0]         cfg_data = '0;
  logic               result_valid;
  logic               kind;
  logic [15:0]        unit_index;
  logic [6:0]         count_at_abund;
  logic signed [7:0]  top_level;
  logic [16:0]        cell_value;

  occupancy_scoreboard sb = new();
  int cycles = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;

  abundance_threshold_occupancy_table_core dut (
    .clk, .rst, .start, .busy, .cmd, .rel_abund, .last_sample, .read_level, .read_rank,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data, .result_valid, .kind, .unit_index,
    .count_at_abund, .top_level, .cell_value
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    table_result_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[abundance_threshold_occupancy_table_core] ERROR");
      $finish;
    end
    if (!rst && result_valid) begin
      got.kind = kind;
      got.unit_index = unit_index;
      got.count_at_abund = count_at_abund;
      got.top_level = top_level;
      got.cell_value = cell_value;
      sb.check_result(got);
    end
  end

  // Leaves start high; it drops start itself for idle gaps when idle_on, and drain lowers it.
  task automatic issue(logic [1:0] c, logic [16:0] rel, logic lst,
                       logic [6:0] rlvl, logic [6:0] rrank);
    if (idle_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    rel_abund <= rel;
    last_sample <= lst;
    read_level <= rlvl;
    read_rank <= rrank;
    do @(posedge clk); while (busy);
    sb.note_input(c, rel, lst, rlvl, rrank);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; configure lowers it after the last beat.
  task automatic write_reg(logic [1:0] addr, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(addr, data);
  endtask

  task automatic configure(logic [7:0] ns, logic [7:0] al, logic [7:0] ms, logic of);
    drain();
    write_reg(REG_NUM_SAMPLES, ns);
    write_reg(REG_ABUND_LEVEL, al);
    write_reg(REG_MIN_SAMPLES, ms);
    write_reg(REG_OUT_FRAC, {7'd0, of});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [16:0] pick_abund();
    int sel = $urandom_range(99);
    if (sel < 5) return 17'd65536;
    if (sel < 10) return 17'($urandom_range(131071));
    if (sel < 15) return 17'd0;
    return 17'($urandom_range(65535));
  endfunction

  // One unit of samples with random content, closed on its final sample.
  task automatic send_unit(int n);
    for (int s = 0; s < n; s++)
      issue(CMD_SAMPLE, pick_abund(), s == n - 1, 7'($urandom), 7'($urandom));
  endtask

  task automatic random_read();
    logic [6:0] lv, rk;
    lv = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    rk = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    issue(CMD_READ, 17'($urandom), 1'b0, lv, rk);
  endtask

  initial begin
    int ns;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read with no units as fraction, abundance extremes, out-of-range reads.
    issue(CMD_READ, 17'd0, 1'b0, 7'd0, 7'd1);
    configure(8'd4, 8'd50, 8'd2, 1'b1);
    issue(CMD_SAMPLE, 17'd0, 1'b0, 7'd0, 7'd0);
    issue(CMD_SAMPLE, 17'd65535, 1'b0, 7'd0, 7'd0);
    issue(CMD_SAMPLE, 17'd131071, 1'b0, 7'd127, 7'd127);
    issue(CMD_SAMPLE, 17'd65536, 1'b1, 7'd0, 7'd0);
    issue(CMD_READ, 17'd0, 1'b0, 7'd100, 7'd4);
    issue(CMD_READ, 17'd0, 1'b0, 7'd127, 7'd1);
    issue(CMD_READ, 17'd0, 1'b0, 7'd0, 7'd0);
    issue(CMD_READ, 17'd0, 1'b0, 7'd0, 7'd5);
    issue(CMD_UNUSED, 17'd131071, 1'b1, 7'd127, 7'd127);
    // More samples than num_samples in one unit.
    for (int i = 0; i < 6; i++) issue(CMD_SAMPLE, 17'd40000, i == 5, 7'd0, 7'd0);
    issue(CMD_READ, 17'd0, 1'b0, 7'd61, 7'd4);
    configure(8'd0, 8'd127, 8'd0, 1'b0);
    issue(CMD_SAMPLE, 17'd655, 1'b1, 7'd0, 7'd0);
    issue(CMD_READ, 17'd0, 1'b0, 7'd0, 7'd1);
    issue(CMD_CLEAR, 17'd0, 1'b0, 7'd0, 7'd0);
    issue(CMD_READ, 17'd0, 1'b0, 7'd0, 7'd1);
    configure(8'd127, 8'd128, 8'd127, 1'b1);
    issue(CMD_SAMPLE, 17'd30000, 1'b1, 7'd0, 7'd0);

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(8'd64, 8'd0, 8'd64, 1'b1);
        1: configure(8'd1, 8'd100, 8'd1, 1'b0);
        2: configure(8'd8, 8'hFF, 8'hFF, 1'b1);
        3: configure(8'd127, 8'd101, 8'd0, 1'b0);
        default: configure(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      endcase
      idle_on = (ph != 2);
      ns = sb.eff_samples();
      while (items_sent < 50 + 125 * (ph + 1)) begin
        case ($urandom_range(19))
          0: issue(CMD_UNUSED, 17'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
          1: if ($urandom_range(3) == 0) issue(CMD_CLEAR, 17'($urandom), 1'($urandom),
                                               7'($urandom), 7'($urandom));
          2, 3, 4, 5: random_read();
          6: issue(CMD_SAMPLE, 17'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
          default: send_unit($urandom_range(9) == 0 ? $urandom_range(1, 70)
                                                    : $urandom_range(1, ns < 8 ? ns + 1 : 8));
        endcase
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[abundance_threshold_occupancy_table_core] OK");
    else
      $display("[abundance_threshold_occupancy_table_core] ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/atot_pkg.sv
hw/rtl/atot_ram.sv
hw/rtl/abundance_threshold_occupancy_table_core.sv
verif/testbench.sv
